[hdl/mask_color_to_instance_index_core_defines.svh]
// Assertion macros shared by the mask decoder RTL.
// All checks are sampled on clk and are off while arst_n is low.
`ifndef MASK_COLOR_TO_INSTANCE_INDEX_CORE_DEFINES_SVH
`define MASK_COLOR_TO_INSTANCE_INDEX_CORE_DEFINES_SVH

// Property that must hold at every sampled edge.
`define MCII_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define MCII_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mcii_pkg.sv]
package mcii_pkg;

	// Field widths fixed by the interface
	localparam int COLOR_W = 24;
	localparam int CHAN_W  = 8;
	localparam int IDX_W   = 15;

	// Channel value table
	localparam int TABLE_LEN        = 32;
	localparam int PALETTE_SIZE_DEF = 32;

	localparam logic [CHAN_W-1:0] CHAN_TABLE [TABLE_LEN] = '{
		8'd0,   8'd255, 8'd127, 8'd63,  8'd191, 8'd31,  8'd95,  8'd159,
		8'd223, 8'd15,  8'd47,  8'd79,  8'd111, 8'd143, 8'd175, 8'd207,
		8'd239, 8'd7,   8'd23,  8'd39,  8'd55,  8'd71,  8'd87,  8'd103,
		8'd119, 8'd135, 8'd151, 8'd167, 8'd183, 8'd199, 8'd215, 8'd231
	};

	// Control that travels with each word down the pipe
	typedef struct packed {
		logic valid;
		logic hit;
	} mcii_ctl_t;

endpackage

[hdl/mcii_lookup.sv]
module mcii_lookup #(
	parameter int PALETTE_SIZE = mcii_pkg::PALETTE_SIZE_DEF,
	localparam int PW = $clog2(PALETTE_SIZE)
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [mcii_pkg::CHAN_W-1:0] chan,
	output logic [PW-1:0]             pos_s1,
	output logic                      hit_s1
);
	import mcii_pkg::*;

	logic [PW-1:0] pos;
	logic          found;

	// Parallel compare against the table; lowest matching position wins
	always_comb begin
		pos   = '0;
		found = 1'b0;
		for (int j = TABLE_LEN - 1; j >= 0; j--) begin
			if ((j < PALETTE_SIZE) && (CHAN_TABLE[j] == chan)) begin
				found = 1'b1;
				pos   = PW'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= pos;
			hit_s1 <= found;
		end
	end

endmodule

[hdl/mcii_select.sv]
module mcii_select #(
	parameter int PALETTE_SIZE = mcii_pkg::PALETTE_SIZE_DEF,
	localparam int PW = $clog2(PALETTE_SIZE),
	localparam int CW = (PW > 2) ? PW : 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  mcii_pkg::mcii_ctl_t ctl_s1,
	input  logic [PW-1:0]       p0_s1,
	input  logic [PW-1:0]       p1_s1,
	input  logic [PW-1:0]       p2_s1,
	output mcii_pkg::mcii_ctl_t ctl_s2,
	output logic [PW-1:0]       m_s2,
	output logic [1:0]          c2_s2,
	output logic [CW-1:0]       c1_s2,
	output logic [PW-1:0]       c0_s2
);
	import mcii_pkg::*;

	logic [PW-1:0] m;
	logic [2:0]    eq;
	logic [1:0]    c2;
	logic [CW-1:0] c1;
	logic [PW-1:0] c0;

	// Largest position and which channels carry it
	always_comb begin
		m = p0_s1;
		if (p1_s1 > m) m = p1_s1;
		if (p2_s1 > m) m = p2_s1;
		eq = {p2_s1 == m, p1_s1 == m, p0_s1 == m};
	end

	// Index = m^3 + c2*m^2 + c1*m + c0, coefficients picked per case
	always_comb begin
		case (eq)
			3'b111: begin
				c2 = 2'd3; c1 = CW'(3);     c0 = '0;
			end
			3'b011: begin
				c2 = 2'd3; c1 = CW'(2);     c0 = p2_s1;
			end
			3'b101: begin
				c2 = 2'd3; c1 = CW'(1);     c0 = p1_s1;
			end
			3'b110: begin
				c2 = 2'd3; c1 = CW'(0);     c0 = p0_s1;
			end
			3'b001: begin
				c2 = 2'd0; c1 = CW'(p1_s1); c0 = p2_s1;
			end
			3'b010: begin
				c2 = 2'd1; c1 = CW'(p0_s1); c0 = p2_s1;
			end
			3'b100: begin
				c2 = 2'd2; c1 = CW'(p0_s1); c0 = p1_s1;
			end
			default: begin
				c2 = 2'd0; c1 = '0;         c0 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2  <= m;
			c2_s2 <= c2;
			c1_s2 <= c1;
			c0_s2 <= c0;
		end
	end

endmodule

[hdl/mcii_arith.sv]
module mcii_arith #(
	parameter int PALETTE_SIZE = mcii_pkg::PALETTE_SIZE_DEF,
	localparam int PW = $clog2(PALETTE_SIZE),
	localparam int CW = (PW > 2) ? PW : 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  mcii_pkg::mcii_ctl_t        ctl_s2,
	input  logic [PW-1:0]              m_s2,
	input  logic [1:0]                 c2_s2,
	input  logic [CW-1:0]              c1_s2,
	input  logic [PW-1:0]              c0_s2,
	output logic                       valid_s4,
	output logic [mcii_pkg::IDX_W-1:0] index_s4,
	output logic                       hit_s4
);
	import mcii_pkg::*;

	localparam int SW = 3 * PW + 2;

	mcii_ctl_t        ctl_s3;
	logic [PW-1:0]    m_s3;
	logic [1:0]       c2_s3;
	logic [PW-1:0]    c0_s3;
	logic [2*PW-1:0]  m2_s3;
	logic [PW+CW-1:0] mc1_s3;

	logic [2*PW-1:0]  m2;
	logic [PW+CW-1:0] mc1;
	logic [3*PW-1:0]  m3;
	logic [2*PW+1:0]  m2c2;
	logic [SW-1:0]    sum;

	// Stage 3: square and linear term
	assign m2  = (2*PW)'(m_s2) * (2*PW)'(m_s2);
	assign mc1 = (PW+CW)'(m_s2) * (PW+CW)'(c1_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3   <= m_s2;
			c2_s3  <= c2_s2;
			c0_s3  <= c0_s2;
			m2_s3  <= m2;
			mc1_s3 <= mc1;
		end
	end

	// Stage 4: cube, square term, final sum
	assign m3   = (3*PW)'(m2_s3) * (3*PW)'(m_s3);
	assign m2c2 = (2*PW+2)'(m2_s3) * (2*PW+2)'(c2_s3);
	assign sum  = SW'(m3) + SW'(m2c2) + SW'(mc1_s3) + SW'(c0_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= ctl_s3.valid;
		end
	end

	// Miss forces a zero index
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4   <= ctl_s3.hit;
			index_s4 <= ctl_s3.hit ? IDX_W'(sum) : '0;
		end
	end

endmodule

[hdl/mask_color_to_instance_index_core.sv]
// Decodes one RGB mask pixel per cycle, unless the output stalls, into its
// instance number. Each channel is mapped to its position in the fixed
// channel table (first PALETTE_SIZE entries); a channel not found gives index
// 0 with palette_hit low. The pipe is four register stages deep: table
// compare, max/case select, square, then cube and sum into the output
// register. All stages advance together: color_ready is high whenever the
// output register is empty or being taken, so holding result_ready low
// while result_valid is high freezes the whole pipe in place.
`include "mask_color_to_instance_index_core_defines.svh"

module mask_color_to_instance_index_core #(
	parameter int PALETTE_SIZE = mcii_pkg::PALETTE_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mcii_pkg::COLOR_W-1:0] mask_color,
	input  logic                         color_valid,
	output logic                         color_ready,
	output logic [mcii_pkg::IDX_W-1:0]   instance_index,
	output logic                         palette_hit,
	output logic                         result_valid,
	input  logic                         result_ready
);
	import mcii_pkg::*;

	localparam int PW = $clog2(PALETTE_SIZE);
	localparam int CW = (PW > 2) ? PW : 2;

	logic          en;
	logic          valid_s1;
	logic [PW-1:0] p0_s1;
	logic [PW-1:0] p1_s1;
	logic [PW-1:0] p2_s1;
	logic          h0_s1;
	logic          h1_s1;
	logic          h2_s1;
	mcii_ctl_t     ctl_s1;
	mcii_ctl_t     ctl_s2;
	logic [PW-1:0] m_s2;
	logic [1:0]    c2_s2;
	logic [CW-1:0] c1_s2;
	logic [PW-1:0] c0_s2;

	// Global pipe advance
	assign en          = !result_valid || result_ready;
	assign color_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= color_valid;
		end
	end

	// Stage 1: one table compare per channel
	mcii_lookup #(.PALETTE_SIZE(PALETTE_SIZE)) u_lookup_r (
		.clk    (clk),
		.en     (en),
		.chan   (mask_color[23:16]),
		.pos_s1 (p0_s1),
		.hit_s1 (h0_s1)
	);

	mcii_lookup #(.PALETTE_SIZE(PALETTE_SIZE)) u_lookup_g (
		.clk    (clk),
		.en     (en),
		.chan   (mask_color[15:8]),
		.pos_s1 (p1_s1),
		.hit_s1 (h1_s1)
	);

	mcii_lookup #(.PALETTE_SIZE(PALETTE_SIZE)) u_lookup_b (
		.clk    (clk),
		.en     (en),
		.chan   (mask_color[7:0]),
		.pos_s1 (p2_s1),
		.hit_s1 (h2_s1)
	);

	assign ctl_s1.valid = valid_s1;
	assign ctl_s1.hit   = h0_s1 & h1_s1 & h2_s1;

	// Stage 2: max position and coefficient select
	mcii_select #(.PALETTE_SIZE(PALETTE_SIZE)) u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_s1 (ctl_s1),
		.p0_s1  (p0_s1),
		.p1_s1  (p1_s1),
		.p2_s1  (p2_s1),
		.ctl_s2 (ctl_s2),
		.m_s2   (m_s2),
		.c2_s2  (c2_s2),
		.c1_s2  (c1_s2),
		.c0_s2  (c0_s2)
	);

	// Stages 3 and 4: polynomial and output register
	mcii_arith #(.PALETTE_SIZE(PALETTE_SIZE)) u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s2   (ctl_s2),
		.m_s2     (m_s2),
		.c2_s2    (c2_s2),
		.c1_s2    (c1_s2),
		.c0_s2    (c0_s2),
		.valid_s4 (result_valid),
		.index_s4 (instance_index),
		.hit_s4   (palette_hit)
	);

	// Checks
	`MCII_ASSERT(a_miss_zero, !(result_valid && !palette_hit) || (instance_index == '0), "miss with nonzero index")
	`MCII_ASSERT_NEXT(a_accept_s1, color_valid && color_ready, valid_s1, "accepted word not in stage 1")
	`MCII_ASSERT_NEXT(a_stall_s2, ctl_s2.valid && !color_ready, ctl_s2.valid && $stable(m_s2), "stage 2 moved during stall")
	`MCII_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(instance_index) && $stable(palette_hit), "output word changed while waiting")

endmodule
